// File: src/assert_macros.svh
// Assertion helpers used by the checker file.
// Each macro expands to one labelled concurrent assertion, clocked on the
// rising edge and switched off while reset is held low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: ante |-> cons");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: ante |=> cons");

`endif

// File: src/lmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmf_pkg
// Types and constants for the three-wire LED matrix framer.
// ----------------------------------------------------------------------------
package lmf_pkg;

    localparam int FRAME_BITS      = 18;
    localparam int COUNT_W         = 5;
    localparam int BYTE_BITS       = 8;
    localparam int ADDR_BITS       = 7;
    localparam int PREFIX_BITS     = 3;

    localparam logic [COUNT_W-1:0] CMD_FRAME_BITS   = 5'd12;
    localparam logic [COUNT_W-1:0] DATA_FIRST_BITS  = 5'd18;
    localparam logic [COUNT_W-1:0] DATA_BYTE_BITS   = 5'd8;

    // Prefixes, in wire order from bit 0 upward
    localparam logic [PREFIX_BITS-1:0] PREFIX_CMD  = 3'b001;  // 1,0,0
    localparam logic [PREFIX_BITS-1:0] PREFIX_DATA = 3'b101;  // 1,0,1

    typedef enum logic
    {
        OP_COMMAND = 1'b0,
        OP_DATA    = 1'b1
    } lmf_op_t;

    typedef struct packed
    {
        logic [BYTE_BITS-1:0] run_length;
        logic [ADDR_BITS-1:0] start_address;
        logic [BYTE_BITS-1:0] value;
        lmf_op_t              opcode;
    } lmf_item_t;

    // One burst of wire bits; bit 0 leaves first
    typedef struct packed
    {
        logic [FRAME_BITS-1:0] bits;
        logic [COUNT_W-1:0]    count;
        logic                  start;
        logic                  last;
    } lmf_frame_t;

endpackage

// File: src/led_matrix_three_wire_framer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_three_wire_framer_top
// Command and display-data words in, strobe-framed serial bit words out.
//
//   channel  direction  handshake          payload
//   s_*      in         tvalid/tready      tuser opcode, tdata value/addr/length
//   m_*      out        tvalid/tready      tdata wire bit, tuser start, tlast end
//   cfg_*    in         write enable only  com_mode
//
// One output word per wire bit: 12 for a command, 18 for the first byte of a
// run, 8 for each further kept byte; the shift register sets that rate.
// A word giving no bits leaves the input register without waiting on the output.
// The next burst loads in the cycle its predecessor's last bit is taken, so
// the output stays busy with no gap while input keeps up.
// Reset clears the run state and selects com_mode 1, the wide RAM size.
// ----------------------------------------------------------------------------
module led_matrix_three_wire_framer_top #(
    parameter int RAM_BYTES_WIDE   = 64,
    parameter int RAM_BYTES_NARROW = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,    // com_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,      // [7:0] value, [14:8] start_address,
                                      // [22:15] run_length, [23] zero
    input  logic        s_tuser,      // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,      // [0] wire_bit, [7:1] zero
    output logic        m_tuser,      // frame_start
    output logic        m_tlast       // frame_end
);
    import lmf_pkg::*;

    logic       item_valid_reg;
    lmf_item_t  item_reg;
    lmf_frame_t plan;
    logic       load_ok;
    logic       consume;
    logic       load;

    assign consume  = item_valid_reg && ((plan.count == '0) || load_ok);
    assign load     = consume && (plan.count != '0);
    assign s_tready = !item_valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            item_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.opcode        <= lmf_op_t'(s_tuser);
            item_reg.value         <= s_tdata[7:0];
            item_reg.start_address <= s_tdata[14:8];
            item_reg.run_length    <= s_tdata[22:15];
        end
    end

    lmf_run_ctrl #(
        .RAM_BYTES_WIDE   (RAM_BYTES_WIDE),
        .RAM_BYTES_NARROW (RAM_BYTES_NARROW)
    ) u_run_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (item_reg),
        .step      (consume),
        .plan      (plan)
    );

    lmf_serializer u_serializer (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .frame    (plan),
        .load_ok  (load_ok),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: src/lmf_run_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmf_run_ctrl
// Run tracking and frame planning: turns one held word into a burst of bits, or into none.
// ----------------------------------------------------------------------------
module lmf_run_ctrl #(
    parameter int RAM_BYTES_WIDE   = 64,
    parameter int RAM_BYTES_NARROW = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    input  lmf_pkg::lmf_item_t item,
    input  logic               step,
    output lmf_pkg::lmf_frame_t plan
);
    import lmf_pkg::*;

    localparam logic [BYTE_BITS-1:0] RAM_WIDE_W   = BYTE_BITS'(RAM_BYTES_WIDE);
    localparam logic [BYTE_BITS-1:0] RAM_NARROW_W = BYTE_BITS'(RAM_BYTES_NARROW);

    logic                 com_mode_reg;
    logic [BYTE_BITS-1:0] to_accept_reg;
    logic [BYTE_BITS-1:0] to_accept_next;
    logic [BYTE_BITS-1:0] to_send_reg;
    logic [BYTE_BITS-1:0] to_send_next;

    logic [BYTE_BITS-1:0] ram_size;
    logic [BYTE_BITS:0]   addr_ext;
    logic [BYTE_BITS:0]   run_end;
    logic [BYTE_BITS-1:0] kept;
    logic                 run_open;

    always_comb
    begin
        ram_size = com_mode_reg ? RAM_WIDE_W : RAM_NARROW_W;
        addr_ext = {2'b00, item.start_address};
        run_end  = addr_ext + {1'b0, item.run_length};
        run_open = (to_accept_reg != '0);
        if (run_end > {1'b0, ram_size})
        begin
            kept = ram_size - addr_ext[BYTE_BITS-1:0];
        end
        else
        begin
            kept = item.run_length;
        end
    end

    always_comb
    begin
        plan           = '0;
        to_accept_next = to_accept_reg;
        to_send_next   = to_send_reg;
        if (item.opcode == OP_COMMAND)
        begin
            // ignore commands inside an open run
            if (!run_open)
            begin
                plan.bits[PREFIX_BITS-1:0] = PREFIX_CMD;
                for (int k = 0; k < BYTE_BITS; k++)
                begin
                    plan.bits[PREFIX_BITS+k] = item.value[BYTE_BITS-1-k];
                end
                plan.count = CMD_FRAME_BITS;
                plan.start = 1'b1;
                plan.last  = 1'b1;
            end
        end
        else if (run_open)
        begin
            to_accept_next = to_accept_reg - 1'b1;
            if (to_send_reg != '0)
            begin
                to_send_next               = to_send_reg - 1'b1;
                plan.bits[BYTE_BITS-1:0]   = item.value;
                plan.count                 = DATA_BYTE_BITS;
                plan.last                  = (to_send_reg == BYTE_BITS'(1));
            end
        end
        else if (item.run_length != '0)
        begin
            to_accept_next = item.run_length - 1'b1;
            if (addr_ext >= {1'b0, ram_size})
            begin
                // address off the end of RAM: swallow the whole run
                to_send_next = '0;
            end
            else
            begin
                to_send_next = kept - 1'b1;
                plan.bits[PREFIX_BITS-1:0] = PREFIX_DATA;
                for (int k = 0; k < ADDR_BITS; k++)
                begin
                    plan.bits[PREFIX_BITS+k] = item.start_address[ADDR_BITS-1-k];
                end
                plan.bits[FRAME_BITS-1 -: BYTE_BITS] = item.value;
                plan.count = DATA_FIRST_BITS;
                plan.start = 1'b1;
                plan.last  = (kept == BYTE_BITS'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            com_mode_reg  <= 1'b1;
            to_accept_reg <= '0;
            to_send_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                com_mode_reg <= cfg_wdata;
            end
            if (step)
            begin
                to_accept_reg <= to_accept_next;
                to_send_reg   <= to_send_next;
            end
        end
    end

endmodule

// File: src/lmf_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmf_serializer
// Shift register that plays one planned burst out, one wire bit per word.
// ----------------------------------------------------------------------------
module lmf_serializer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  lmf_pkg::lmf_frame_t frame,
    output logic                load_ok,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,    // [0] wire_bit, [7:1] zero
    output logic                m_tuser,    // frame_start
    output logic                m_tlast     // frame_end
);
    import lmf_pkg::*;

    logic [FRAME_BITS-1:0] bits_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic                  start_reg;
    logic                  last_reg;
    logic                  pop;

    assign pop      = m_tvalid && m_tready;
    assign load_ok  = (count_reg == '0) || ((count_reg == COUNT_W'(1)) && m_tready);
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {7'b0, bits_reg[0]};
    assign m_tuser  = start_reg;
    assign m_tlast  = last_reg && (count_reg == COUNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            start_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else if (load)
        begin
            count_reg <= frame.count;
            start_reg <= frame.start;
            last_reg  <= frame.last;
        end
        else if (pop)
        begin
            count_reg <= count_reg - 1'b1;
            start_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bits_reg <= frame.bits;
        end
        else if (pop)
        begin
            bits_reg <= {1'b0, bits_reg[FRAME_BITS-1:1]};
        end
    end

endmodule

// File: src/lmf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmf_checker
// Port-level checks on the framer's output stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lmf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);

    // hold a stalled word
    `ASSERT_NEXT(a_valid_held, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `ASSERT_NEXT(a_word_held, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    // a frame opens with a one bit and never ends on its first bit
    `ASSERT_IMPLIES(a_start_bit, clk, rst_n, m_tvalid && m_tuser, m_tdata[0] && !m_tlast)
    // the bit after a frame start follows at once and opens nothing
    `ASSERT_NEXT(a_after_start, clk, rst_n, m_tvalid && m_tready && m_tuser, m_tvalid && !m_tuser)

endmodule

bind led_matrix_three_wire_framer_top lmf_checker u_lmf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
